FILE: src/periodic_task_release_scheduler_assert.svh
// Assertion macros for the periodic task release scheduler.
// Included by the controller and datapath; no other dependencies.
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// checked at every clock edge outside reset
`define PTRS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ptrs assertion failed");

// checked at every clock edge, reset included
`define PTRS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ptrs assertion failed");

`else

`define PTRS_ASSERT(name, clk, rst, prop)
`define PTRS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: src/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
// No dependencies.
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam int CH_MAX            = 4;
  localparam int NUM_TASKS_DEFAULT = 4;
  localparam int TIME_W            = 32;
  localparam int PERIOD_W          = 31;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 31;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd1000;
  localparam logic [CH_MAX-1:0]   PMASK_RESET  = 4'hF;

  typedef enum logic [2:0] {
    OP_POLL    = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_TOGGLE  = 3'd3,
    OP_DROP_NP = 3'd4,
    OP_START   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD0 = 3'd0,
    CFG_PERIOD1 = 3'd1,
    CFG_PERIOD2 = 3'd2,
    CFG_PERIOD3 = 3'd3,
    CFG_PMASK   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        task_index;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic [CH_MAX-1:0] fire_mask;
    logic [CH_MAX-1:0] enable_mask;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: src/ptrs_ctrl.sv
// Item sequencing controller: capture, execute, result hold.
// Depends on ptrs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "periodic_task_release_scheduler_assert.svh"

module ptrs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ptrs_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.load = req_valid && req_ready;
    cmd.exec = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // one item in flight
  `PTRS_ASSERT(a_load_busy, clk, rst, cmd.load |=> !req_ready)
  // result lands in the output register and input reopens
  `PTRS_ASSERT(a_exec_done, clk, rst, cmd.exec |=> (rsp_valid && req_ready))
  // execution waits while the held result is not taken
  `PTRS_ASSERT(a_exec_wait, clk, rst,
    ((state == S_EXEC) && rsp_valid && !rsp_ready) |=> (state == S_EXEC))

endmodule

FILE: src/ptrs_dp.sv
// Datapath: channel bank (due times, enables), config registers, result register.
// Depends on ptrs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "periodic_task_release_scheduler_assert.svh"

module ptrs_dp #(
  parameter int NUM_TASKS = ptrs_pkg::NUM_TASKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptrs_pkg::cmd_t                  cmd,
  input  ptrs_pkg::req_t                  req,
  output ptrs_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data
);

  ptrs_pkg::req_t req_q;
  ptrs_pkg::rsp_t rsp_q;

  logic [ptrs_pkg::PERIOD_W-1:0] period [ptrs_pkg::CH_MAX];
  logic [ptrs_pkg::CH_MAX-1:0]   pmask;

  logic [ptrs_pkg::TIME_W-1:0] due      [NUM_TASKS];
  logic [ptrs_pkg::TIME_W-1:0] due_next [NUM_TASKS];
  logic [NUM_TASKS-1:0]        en;
  logic [NUM_TASKS-1:0]        en_next;
  logic [NUM_TASKS-1:0]        fire;

  assign rsp = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptrs_pkg::CH_MAX; i++) begin
        period[i] <= ptrs_pkg::PERIOD_RESET;
      end
      pmask <= ptrs_pkg::PMASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptrs_pkg::CFG_PERIOD0: period[0] <= cfg_data;
        ptrs_pkg::CFG_PERIOD1: period[1] <= cfg_data;
        ptrs_pkg::CFG_PERIOD2: period[2] <= cfg_data;
        ptrs_pkg::CFG_PERIOD3: period[3] <= cfg_data;
        ptrs_pkg::CFG_PMASK:   pmask     <= cfg_data[ptrs_pkg::CH_MAX-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= req;
  end

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_ch
    logic [ptrs_pkg::TIME_W-1:0] diff;
    logic [ptrs_pkg::TIME_W-1:0] step;

    assign diff = req_q.now_time - due[g];
    assign step = {1'b0, period[g]};

    always_comb begin
      fire[g]     = 1'b0;
      en_next[g]  = en[g];
      due_next[g] = due[g];
      unique case (req_q.op)
        ptrs_pkg::OP_POLL: begin
          if (en[g] && !diff[ptrs_pkg::TIME_W-1]) begin
            fire[g]     = 1'b1;
            due_next[g] = due[g] + step;
          end
        end
        ptrs_pkg::OP_ENABLE: begin
          if (req_q.task_index == 2'(g)) en_next[g] = 1'b1;
        end
        ptrs_pkg::OP_DISABLE: begin
          if (req_q.task_index == 2'(g)) en_next[g] = 1'b0;
        end
        ptrs_pkg::OP_TOGGLE: begin
          if (req_q.task_index == 2'(g)) en_next[g] = !en[g];
        end
        ptrs_pkg::OP_DROP_NP: begin
          en_next[g] = en[g] && pmask[g];
        end
        ptrs_pkg::OP_START: begin
          en_next[g]  = en[g] && pmask[g];
          due_next[g] = req_q.now_time + step;
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        en[g]  <= 1'b1;
        due[g] <= '0;
      end else if (cmd.exec) begin
        en[g]  <= en_next[g];
        due[g] <= due_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_q.fire_mask   <= ptrs_pkg::CH_MAX'(fire);
      rsp_q.enable_mask <= ptrs_pkg::CH_MAX'(en_next);
    end
  end

  // only polls release channels
  `PTRS_ASSERT(a_fire_poll_only, clk, rst,
    (cmd.exec && (req_q.op != ptrs_pkg::OP_POLL)) |=> (rsp_q.fire_mask == '0))
  // a released channel was enabled and a poll leaves it enabled
  `PTRS_ASSERT(a_fire_enabled, clk, rst,
    (cmd.exec && (req_q.op == ptrs_pkg::OP_POLL)) |=>
      ((rsp_q.fire_mask & ~rsp_q.enable_mask) == '0))
  // result register only changes on execute
  `PTRS_ASSERT(a_rsp_hold, clk, rst, !cmd.exec |=> $stable(rsp_q))

endmodule

FILE: src/periodic_task_release_scheduler.sv
// Top level of the periodic task release scheduler.
// Depends on ptrs_pkg, ptrs_ctrl and ptrs_dp.
//
//   channel  | signals                       | role
//   req      | req_valid, req_ready, req     | operation item in (op, task_index, now_time)
//   rsp      | rsp_valid, rsp_ready, rsp     | result item out (fire_mask, enable_mask)
//   cfg      | cfg_we, cfg_index, cfg_data   | register writes, one per cycle, no wait
//
// Each item is captured into the request register, then updates the channel bank
// in the execute state; the single-item controller takes no new item until it has executed.
// A result not yet taken holds execution of the next item until rsp_ready.
// Reset is synchronous: all channels enabled, due times zero, periods 1000,
// persistent mask all ones.
`timescale 1ns / 1ps

module periodic_task_release_scheduler #(
  parameter int NUM_TASKS = ptrs_pkg::NUM_TASKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  ptrs_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output ptrs_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_data
);

  ptrs_pkg::cmd_t cmd;

  ptrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  ptrs_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
